// ===== hw/rtl/mpa_pkg.sv =====
package mpa_pkg;

  // Limits of the pooling geometry
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_BITS  = 32;

  // Register and field widths
  localparam int DIM_W      = 11;               // input_width / input_height
  localparam int K_W        = 5;                // channel_total / window_size
  localparam int VAL_W      = 32;               // Q16.16 values
  localparam int POS_W      = 24;               // flat input position
  localparam int IDX_W      = 25;               // signed result index
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  // Counter widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CH_W   = $clog2(MAX_CHANNELS);
  localparam int PH_W   = $clog2(MAX_WINDOW);
  localparam int EXT_W  = DIM_W + 1;             // geometry sums with headroom
  localparam int DVD_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int STEP_W = $clog2(DVD_W);
  localparam int LINE_DEPTH = MAX_WIDTH;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_WIDTH   = 3'd0,
    REG_INPUT_HEIGHT  = 3'd1,
    REG_CHANNEL_TOTAL = 3'd2,
    REG_WINDOW_SIZE   = 3'd3,
    REG_FLOOR_VALUE   = 3'd4
  } cfg_reg_t;

  localparam logic [DIM_W-1:0]        WIDTH_RESET   = 11'd28;
  localparam logic [DIM_W-1:0]        HEIGHT_RESET  = 11'd28;
  localparam logic [K_W-1:0]          CHANNEL_RESET = 5'd1;
  localparam logic [K_W-1:0]          WINDOW_RESET  = 5'd2;
  localparam logic signed [VAL_W-1:0] FLOOR_RESET   = -32'sd65470464;  // -999.0
  localparam logic [IDX_W-1:0]        NO_INDEX      = '1;              // -1

  // One entry of the partial-maximum line
  typedef struct packed {
    logic                    found;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } line_entry_t;

  // Control carried with a sample into the compare stage
  typedef struct packed {
    logic               start;   // first sample of its window
    logic               emit;    // last sample of a complete window
    logic               in_win;  // sample lies in a complete window
    logic               last;    // window is the last one of the image
    logic [LINE_AW-1:0] addr;    // output column
  } slot_ctrl_t;

  // Zero acts as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [K_W-1:0] clamp_small(input logic [K_W-1:0] v,
                                                 input logic [K_W-1:0] hi);
    logic [K_W-1:0] r;
    if (v == '0) begin
      r = K_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/max_pool_with_argmax_unit.sv =====
// Channel   Dir  Beat fields (low bit up)
// s_axis    in   s_tdata: sample[31:0]
// m_axis    out  m_tdata: max_value[31:0], arg_index[56:32], zero[63:57]; m_tlast: image_done
// cfg       in   cfg_index: register number, cfg_data: value (low bits used)
//
// One sample per cycle sustained while s_tready is high; the last sample of a window
// passes the compare stage register, then the result register. The line
// read-compare-write on one output column sets that rate. After reset and after every
// configuration write the block rebuilds its window phases (ST_DIV), then its position
// bases (ST_MUL_A, ST_MUL_B); s_tready is low meanwhile. Reset is synchronous, active
// high. A stalled result holds an emitting compare stage; input is taken while it can drain.
module max_pool_with_argmax_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mpa_pkg::IN_TDATA_W-1:0]    s_tdata,   // sample[31:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mpa_pkg::OUT_TDATA_W-1:0]   m_tdata,   // max_value, arg_index, pad
  output logic                              m_tlast,   // image_done
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mpa_pkg::*;

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_MUL_A = 4'b0100,
    ST_MUL_B = 4'b1000
  } state_t;

  // Configuration registers
  logic [DIM_W-1:0]        width_r, height_r;
  logic [K_W-1:0]          chan_r, win_r;
  logic signed [VAL_W-1:0] floor_r;
  logic [DIM_W-1:0]        w_eff, h_eff;
  logic [K_W-1:0]          c_eff, k_eff;

  // Scan position
  state_t             state;
  logic [COL_W-1:0]   col, oc;
  logic [ROW_W-1:0]   row;
  logic [CH_W-1:0]    ch;
  logic [PH_W-1:0]    cph, rph;
  logic [POS_W-1:0]   row_base, chan_base, hw;

  // Phase rebuild divider
  logic [DVD_W-1:0]   col_dvd, row_dvd, col_quo, col_quo_next;
  logic [K_W-1:0]     col_rem, row_rem, col_rem_next, row_rem_next;
  logic [K_W:0]       col_trial, row_trial;
  logic               col_ge, row_ge;
  logic [STEP_W-1:0]  div_step;

  // Handshakes
  logic s_fire, cfg_fire, s1_adv;

  // Slot geometry
  logic [EXT_W-1:0]   col_start, col_end, row_start, row_end;
  logic               in_col, in_row, last_col, last_row;
  logic               col_wrap, row_wrap, ch_wrap, cph_wrap, rph_wrap;
  logic [POS_W-1:0]   flat;
  slot_ctrl_t         ctrl0;

  // Compare stage
  logic                    s1_valid;
  logic signed [VAL_W-1:0] s1_sample;
  slot_ctrl_t              s1_ctrl;
  logic [POS_W-1:0]        s1_pos;
  logic                    s1_fwd;
  line_entry_t             s1_fwd_data, rd_data, base, upd;
  logic                    line_we;
  line_entry_t             line_mem [LINE_DEPTH];

  // Result register
  logic signed [VAL_W-1:0] m_value;
  logic [IDX_W-1:0]        m_index;

  assign w_eff = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
  assign h_eff = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));
  assign c_eff = clamp_small(chan_r, K_W'(MAX_CHANNELS));
  assign k_eff = clamp_small(win_r, K_W'(MAX_WINDOW));

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign s1_adv    = s1_valid & (~s1_ctrl.emit | ~m_tvalid | m_tready);
  assign s_tready  = (state == ST_RUN) & ~cfg_valid & (~s1_valid | s1_adv);
  assign s_fire    = s_tvalid & s_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      chan_r   <= CHANNEL_RESET;
      win_r    <= WINDOW_RESET;
      floor_r  <= FLOOR_RESET;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_INPUT_WIDTH:   width_r  <= cfg_data[DIM_W-1:0];
        REG_INPUT_HEIGHT:  height_r <= cfg_data[DIM_W-1:0];
        REG_CHANNEL_TOTAL: chan_r   <= cfg_data[K_W-1:0];
        REG_WINDOW_SIZE:   win_r    <= cfg_data[K_W-1:0];
        REG_FLOOR_VALUE:   floor_r  <= $signed(cfg_data[VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  // Restoring divide step, one quotient bit per cycle
  always_comb begin
    col_trial    = {col_rem, col_dvd[DVD_W-1]};
    row_trial    = {row_rem, row_dvd[DVD_W-1]};
    col_ge       = col_trial >= {1'b0, k_eff};
    row_ge       = row_trial >= {1'b0, k_eff};
    col_rem_next = col_ge ? K_W'(col_trial - {1'b0, k_eff}) : col_trial[K_W-1:0];
    row_rem_next = row_ge ? K_W'(row_trial - {1'b0, k_eff}) : row_trial[K_W-1:0];
    col_quo_next = {col_quo[DVD_W-2:0], col_ge};
  end

  // Geometry of the current slot
  always_comb begin
    col_start = EXT_W'(col) - EXT_W'(cph);
    col_end   = col_start + EXT_W'(k_eff);
    row_start = EXT_W'(row) - EXT_W'(rph);
    row_end   = row_start + EXT_W'(k_eff);
    in_col    = col_end <= EXT_W'(w_eff);
    in_row    = row_end <= EXT_W'(h_eff);
    last_col  = (col_end + EXT_W'(k_eff)) > EXT_W'(w_eff);
    last_row  = (row_end + EXT_W'(k_eff)) > EXT_W'(h_eff);
    cph_wrap  = (K_W'(cph) + K_W'(1)) == k_eff;
    rph_wrap  = (K_W'(rph) + K_W'(1)) == k_eff;
    col_wrap  = (EXT_W'(col) + EXT_W'(1)) >= EXT_W'(w_eff);
    row_wrap  = (EXT_W'(row) + EXT_W'(1)) >= EXT_W'(h_eff);
    ch_wrap   = (K_W'(ch) + K_W'(1)) >= c_eff;
    flat      = chan_base + row_base + POS_W'(col);

    ctrl0.start  = (cph == '0) & (rph == '0);
    ctrl0.in_win = in_col & in_row;
    ctrl0.emit   = in_col & in_row & cph_wrap & rph_wrap;
    ctrl0.last   = ((K_W'(ch) + K_W'(1)) == c_eff) & last_row & last_col;
    ctrl0.addr   = LINE_AW'(oc);
  end

  // Scan counters and the rebuild sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_DIV;
      col       <= '0;
      row       <= '0;
      ch        <= '0;
      oc        <= '0;
      cph       <= '0;
      rph       <= '0;
      row_base  <= '0;
      chan_base <= '0;
      hw        <= '0;
      col_dvd   <= '0;
      row_dvd   <= '0;
      col_rem   <= '0;
      row_rem   <= '0;
      col_quo   <= '0;
      div_step  <= '0;
    end else if (cfg_fire) begin
      state    <= ST_DIV;
      col_dvd  <= DVD_W'(col);
      row_dvd  <= DVD_W'(row);
      col_rem  <= '0;
      row_rem  <= '0;
      col_quo  <= '0;
      div_step <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (s_fire) begin
            if (!col_wrap) begin
              col <= col + COL_W'(1);
              if (cph_wrap) begin
                cph <= '0;
                oc  <= oc + COL_W'(1);
              end else begin
                cph <= cph + PH_W'(1);
              end
            end else begin
              col <= '0;
              cph <= '0;
              oc  <= '0;
              if (!row_wrap) begin
                row      <= row + ROW_W'(1);
                row_base <= row_base + POS_W'(w_eff);
                rph      <= rph_wrap ? '0 : rph + PH_W'(1);
              end else begin
                row      <= '0;
                rph      <= '0;
                row_base <= '0;
                if (!ch_wrap) begin
                  ch        <= ch + CH_W'(1);
                  chan_base <= chan_base + hw;
                end else begin
                  ch        <= '0;
                  chan_base <= '0;
                end
              end
            end
          end
        end
        ST_DIV: begin
          col_dvd  <= {col_dvd[DVD_W-2:0], 1'b0};
          row_dvd  <= {row_dvd[DVD_W-2:0], 1'b0};
          col_rem  <= col_rem_next;
          row_rem  <= row_rem_next;
          col_quo  <= col_quo_next;
          div_step <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(DVD_W - 1)) begin
            cph   <= PH_W'(col_rem_next);
            rph   <= PH_W'(row_rem_next);
            oc    <= COL_W'(col_quo_next);
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          hw       <= POS_W'(h_eff * w_eff);
          row_base <= POS_W'(row * w_eff);
          state    <= ST_MUL_B;
        end
        ST_MUL_B: begin
          chan_base <= POS_W'(ch * hw);
          state     <= ST_RUN;
        end
        default: state <= ST_DIV;
      endcase
    end
  end

  // Compare stage: merge the sample into its column's partial maximum
  always_comb begin
    if (s1_ctrl.start) begin
      base.found = 1'b0;
      base.pos   = '0;
      base.value = floor_r;
    end else if (s1_fwd) begin
      base = s1_fwd_data;
    end else begin
      base = rd_data;
    end
    if (s1_sample > base.value) begin
      upd.found = 1'b1;
      upd.pos   = s1_pos;
      upd.value = s1_sample;
    end else begin
      upd = base;
    end
  end

  assign line_we = s1_adv & s1_ctrl.in_win;

  // Partial line memory, read at accept, written from the compare stage
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[s1_ctrl.addr] <= upd;
    end
    if (s_fire) begin
      rd_data <= line_mem[ctrl0.addr];
    end
  end

  // Compare stage register; forward when the read and a write to it share an edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
      s1_fwd   <= line_we & (s1_ctrl.addr == ctrl0.addr);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_sample   <= $signed(s_tdata[SAMPLE_BITS-1:0]);
      s1_ctrl     <= ctrl0;
      s1_pos      <= flat;
      s1_fwd_data <= upd;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv & s1_ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv & s1_ctrl.emit) begin
      m_value <= upd.value;
      m_index <= upd.found ? IDX_W'(upd.pos) : NO_INDEX;
      m_tlast <= s1_ctrl.last;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - VAL_W - IDX_W){1'b0}}, m_index, m_value};

endmodule

// ===== hw/rtl/mpa_checker.sv =====
module mpa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mpa_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);
  import mpa_pkg::*;

  localparam int IDX_MSB = VAL_W + IDX_W - 1;

  // A result beat waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // Stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // Reset leaves no result and starts the rebuild pass
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block active right after reset");

  // A register write starts the rebuild pass, so input stops
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("input taken right after a register write");

  // Index is either a position or the no-maximum mark
  a_index_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[IDX_MSB] || (m_tdata[IDX_MSB:VAL_W] == NO_INDEX))
    else $error("malformed result index");

endmodule

bind max_pool_with_argmax_unit mpa_checker u_mpa_checker (.*);
